### rtl/core/b64e_pkg.sv
`timescale 1ns / 1ps

package b64e_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [6:0] out_char;
      logic       out_last;
   } rsp_type;

   // One or two characters produced by a single input byte.
   typedef struct packed {
      rsp_type first;
      rsp_type second;
      logic    two;
   } pair_type;

   // Position of the next byte inside its three-byte group.
   typedef enum logic [2:0] {
      PHASE_FIRST  = 3'b001,
      PHASE_SECOND = 3'b010,
      PHASE_THIRD  = 3'b100
   } phase_type;

   localparam logic [6:0] CHAR_UPPER_BASE = 7'd65;   // 'A'
   localparam logic [6:0] CHAR_LOWER_OFS  = 7'd71;   // 'a' minus 26
   localparam logic [6:0] CHAR_DIGIT_OFS  = 7'd4;    // 52 minus '0'
   localparam logic [6:0] CHAR_PLUS       = 7'd43;   // '+'
   localparam logic [6:0] CHAR_SLASH      = 7'd47;   // '/'
   localparam logic [5:0] SEXTET_LOWER    = 6'd26;
   localparam logic [5:0] SEXTET_DIGIT    = 6'd52;
   localparam logic [5:0] SEXTET_PLUS     = 6'd62;

   function automatic logic [6:0] sextet_char(input logic [5:0] v);
      logic [6:0] r;
      if (v < SEXTET_LOWER) begin
         r = CHAR_UPPER_BASE + {1'b0, v};
      end else if (v < SEXTET_DIGIT) begin
         r = CHAR_LOWER_OFS + {1'b0, v};
      end else if (v < SEXTET_PLUS) begin
         r = {1'b0, v} - CHAR_DIGIT_OFS;
      end else if (v == SEXTET_PLUS) begin
         r = CHAR_PLUS;
      end else begin
         r = CHAR_SLASH;
      end
      return r;
   endfunction

endpackage

### rtl/core/b64e_pack.sv
`timescale 1ns / 1ps

module b64e_pack (
   input  b64e_pkg::req_type   req,
   input  b64e_pkg::phase_type phase,
   input  logic [3:0]          carry,
   output b64e_pkg::pair_type  pair,
   output b64e_pkg::phase_type phase_in,
   output logic [3:0]          carry_in
);

   logic [5:0]          sext0;
   logic [5:0]          sext1;
   logic                two;
   logic                last1;
   logic [3:0]          carry_new;
   b64e_pkg::phase_type phase_new;

   always_comb begin
      sext1 = 6'd0;
      two   = 1'b0;
      last1 = 1'b0;
      unique case (phase)
         b64e_pkg::PHASE_SECOND: begin
            sext0     = {req.data_byte[3:0], carry[1:0]};
            carry_new = req.data_byte[7:4];
            phase_new = b64e_pkg::PHASE_THIRD;
         end
         b64e_pkg::PHASE_THIRD: begin
            sext0     = {req.data_byte[1:0], carry};
            sext1     = req.data_byte[7:2];
            two       = 1'b1;
            last1     = req.last_byte;
            carry_new = 4'd0;
            phase_new = b64e_pkg::PHASE_FIRST;
         end
         default: begin
            sext0     = req.data_byte[5:0];
            carry_new = {2'b00, req.data_byte[7:6]};
            phase_new = b64e_pkg::PHASE_SECOND;
         end
      endcase

      // A message that ends mid-group flushes the held bits as one more character.
      if (req.last_byte) begin
         if (phase_new != b64e_pkg::PHASE_FIRST) begin
            sext1 = {2'b00, carry_new};
            two   = 1'b1;
            last1 = 1'b1;
         end
         carry_new = 4'd0;
         phase_new = b64e_pkg::PHASE_FIRST;
      end

      pair.first.out_char  = b64e_pkg::sextet_char(sext0);
      pair.first.out_last  = req.last_byte & ~two;
      pair.second.out_char = b64e_pkg::sextet_char(sext1);
      pair.second.out_last = last1;
      pair.two             = two;
      phase_in             = phase_new;
      carry_in             = carry_new;
   end

endmodule

### rtl/core/b64e_out.sv
`timescale 1ns / 1ps

module b64e_out (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  b64e_pkg::pair_type pair,
   output logic               load_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output b64e_pkg::rsp_type  rsp_data
);

   logic               pend_valid_ff;
   logic               pend_valid_in;
   logic               pend_sel_ff;
   logic               pend_sel_in;
   b64e_pkg::pair_type pend_ff;
   b64e_pkg::pair_type pend_in;
   logic               out_valid_ff;
   logic               out_valid_in;
   b64e_pkg::rsp_type  out_ff;
   b64e_pkg::rsp_type  out_in;
   logic               out_load;
   logic               pend_done;

   // The output register takes a new character when it is empty or its beat completes.
   assign out_load   = pend_valid_ff & (~out_valid_ff | rsp_ready);
   assign pend_done  = out_load & (~pend_ff.two | pend_sel_ff);
   assign load_ready = ~pend_valid_ff | pend_done;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_sel_in   = pend_sel_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;

      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (out_load) begin
         out_valid_in = 1'b1;
         out_in       = pend_sel_ff ? pend_ff.second : pend_ff.first;
         pend_sel_in  = ~pend_done;
      end
      if (pend_done) begin
         pend_valid_in = 1'b0;
      end
      if (load) begin
         pend_valid_in = 1'b1;
         pend_sel_in   = 1'b0;
         pend_in       = pair;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         pend_sel_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         pend_sel_ff   <= pend_sel_in;
         out_valid_ff  <= out_valid_in;
      end
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

### rtl/core/base64_lsb_first_encoder.sv
`timescale 1ns / 1ps

// Channel  Direction  Payload                          Handshake
// req      in         data_byte[7:0], last_byte        req_valid / req_ready
// rsp      out        out_char[6:0], out_last          rsp_valid / rsp_ready
//
// Each byte yields one or two characters, two when it closes a group or flushes a
// partial one; the result register emits one per cycle while rsp_ready is high.
// A new byte is taken in the cycle its predecessor's last character moves to the
// result register, so an item may follow in the next cycle.
// Reset clears the group position, the held bits and both valid flags.
// A stalled result holds its beat; input stalls while the byte register holds a byte not yet done.

module base64_lsb_first_encoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  b64e_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output b64e_pkg::rsp_type rsp_data
);

   b64e_pkg::phase_type phase_ff;
   b64e_pkg::phase_type phase_in;
   logic [3:0]          carry_ff;
   logic [3:0]          carry_in;
   b64e_pkg::pair_type  pair;
   logic                accept;

   assign accept = req_valid & req_ready;

   b64e_pack u_pack (
      .req      (req_data),
      .phase    (phase_ff),
      .carry    (carry_ff),
      .pair     (pair),
      .phase_in (phase_in),
      .carry_in (carry_in)
   );

   b64e_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .pair       (pair),
      .load_ready (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= b64e_pkg::PHASE_FIRST;
         carry_ff <= 4'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         carry_ff <= carry_in;
      end
   end

endmodule
